[design/ole_pkg.sv]
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine: request and
// response payloads, command and status codes, default sizes.
// ----------------------------------------------------------------------------
package ole_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 16;
    localparam int WORD_WIDTH_DEF = 32;

    // fixed field widths of the request and response
    localparam int CMD_W  = 3;
    localparam int IDX_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;
    localparam int LENO_W = 5;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_REM_POS = 3'd1,
        CMD_REM_VAL = 3'd2,
        CMD_SWAP    = 3'd3,
        CMD_GET     = 3'd4,
        CMD_FIND    = 3'd5,
        CMD_CLEAR   = 3'd6
    } cmd_t;

    // status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // request payload
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic signed [VAL_W-1:0] value_in;
    } req_t;

    // response payload
    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] value_out;
        logic [POS_W-1:0]        position_out;
        logic [LENO_W-1:0]       length_out;
    } rsp_t;

endpackage

[design/ole_mem.sv]
// ----------------------------------------------------------------------------
// ole_mem
// Word store of the list: one write port, one read port, read data
// registered, ready in the cycle after the address.
// ----------------------------------------------------------------------------
module ole_mem #(
    parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = ole_pkg::WORD_WIDTH_DEF,
    localparam int AW        = $clog2(CAPACITY)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [WORD_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [WORD_WIDTH-1:0] rd_data
);

    logic [WORD_WIDTH-1:0] mem [CAPACITY];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/ole_ctrl.sv]
// ----------------------------------------------------------------------------
// ole_ctrl
// Command sequencer: checks a request against the length, then walks the
// store one read a cycle, writing shifted words back behind the reads.
// ----------------------------------------------------------------------------
module ole_ctrl #(
    parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = ole_pkg::WORD_WIDTH_DEF,
    localparam int AW        = $clog2(CAPACITY)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ole_pkg::req_t         req,
    input  logic                  req_valid,
    output logic                  req_stall,
    output ole_pkg::rsp_t         done_rsp,
    output logic                  done_valid,
    input  logic                  done_take,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    input  logic [WORD_WIDTH-1:0] rd_data,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [WORD_WIDTH-1:0] wr_data
);

    import ole_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // control state
    state_t          state_reg, state_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [LW-1:0]   ptr_reg, ptr_next;
    logic [LW-1:0]   end_reg, end_next;
    logic            down_reg, down_next;
    logic            issue_reg, issue_next;
    logic            rdv_reg, rdv_next;
    logic            found_reg, found_next;

    // request and result payload
    cmd_t                    cmd_reg, cmd_next;
    logic [LW-1:0]           a_reg, a_next;
    logic [LW-1:0]           rda_reg, rda_next;
    logic [LW-1:0]           wadr_reg, wadr_next;
    logic [WORD_WIDTH-1:0]   w_reg, w_next;
    logic [WORD_WIDTH-1:0]   hold_reg, hold_next;
    status_t                 status_reg, status_next;
    logic signed [VAL_W-1:0] vout_reg, vout_next;
    logic [POS_W-1:0]        pos_reg, pos_next;

    // incoming request, widened for the range checks
    logic [CW-1:0]         a_cw, b_cw, len_cw;
    logic [WORD_WIDTH-1:0] req_word;
    logic                  hit;

    assign a_cw     = CW'(req.index_a);
    assign b_cw     = CW'(req.index_b);
    assign len_cw   = CW'(len_reg);
    assign req_word = WORD_WIDTH'(req.value_in);
    assign hit      = (rd_data == w_reg);

    assign req_stall  = (state_reg != S_IDLE);
    assign done_valid = (state_reg == S_DONE);

    always_comb
    begin
        done_rsp.status       = status_reg;
        done_rsp.value_out    = vout_reg;
        done_rsp.position_out = pos_reg;
        done_rsp.length_out   = LENO_W'(len_reg);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        ptr_next    = ptr_reg;
        end_next    = end_reg;
        down_next   = down_reg;
        issue_next  = issue_reg;
        rdv_next    = rdv_reg;
        found_next  = found_reg;
        cmd_next    = cmd_reg;
        a_next      = a_reg;
        rda_next    = rda_reg;
        wadr_next   = wadr_reg;
        w_next      = w_reg;
        hold_next   = hold_reg;
        status_next = status_reg;
        vout_next   = vout_reg;
        pos_next    = pos_reg;
        rd_en       = 1'b0;
        rd_addr     = ptr_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = AW'(rda_reg - LW'(1));
        wr_data     = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next    = cmd_t'(req.cmd);
                    a_next      = LW'(a_cw);
                    w_next      = req_word;
                    hold_next   = req_word;
                    status_next = ST_OK;
                    vout_next   = '0;
                    pos_next    = '0;
                    found_next  = 1'b0;
                    rdv_next    = 1'b0;
                    issue_next  = 1'b1;
                    down_next   = 1'b0;
                    state_next  = S_DONE;
                    unique case (cmd_t'(req.cmd))
                        CMD_INSERT:
                        begin
                            if (a_cw > len_cw)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (len_reg == LW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wadr_next = LW'(a_cw);
                                if (a_cw == len_cw)
                                begin
                                    state_next = S_WRITE;
                                end
                                else
                                begin
                                    ptr_next   = len_reg - LW'(1);
                                    end_next   = LW'(a_cw);
                                    down_next  = 1'b1;
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        CMD_REM_POS:
                        begin
                            if (a_cw >= len_cw)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = LW'(a_cw);
                                end_next   = len_reg - LW'(1);
                                state_next = S_SCAN;
                            end
                        end
                        CMD_REM_VAL, CMD_FIND:
                        begin
                            if (len_reg == '0)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                end_next   = len_reg - LW'(1);
                                state_next = S_SCAN;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (a_cw >= len_cw || b_cw >= len_cw || a_cw == b_cw)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = LW'(a_cw);
                                end_next   = LW'(b_cw);
                                wadr_next  = LW'(b_cw);
                                state_next = S_SCAN;
                            end
                        end
                        CMD_GET:
                        begin
                            if (a_cw >= len_cw)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = LW'(a_cw);
                                end_next   = LW'(a_cw);
                                state_next = S_SCAN;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            len_next = '0;
                        end
                        default:
                        begin
                            // unused selector answers ok
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read side: one address a cycle
                rdv_next = issue_reg;
                if (issue_reg)
                begin
                    rd_en    = 1'b1;
                    rda_next = ptr_reg;
                    if (ptr_reg == end_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else if (cmd_reg == CMD_SWAP)
                    begin
                        ptr_next = end_reg;
                    end
                    else if (down_reg)
                    begin
                        ptr_next = ptr_reg - LW'(1);
                    end
                    else
                    begin
                        ptr_next = ptr_reg + LW'(1);
                    end
                end

                // data side: word read last cycle
                if (rdv_reg)
                begin
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(rda_reg + LW'(1));
                        end
                        CMD_REM_POS:
                        begin
                            if (rda_reg == a_reg)
                            begin
                                vout_next = VAL_W'(rd_data);
                            end
                            else
                            begin
                                wr_en = 1'b1;
                            end
                        end
                        CMD_REM_VAL:
                        begin
                            if (found_reg)
                            begin
                                wr_en = 1'b1;
                            end
                            else if (hit)
                            begin
                                found_next = 1'b1;
                                vout_next  = VAL_W'(rd_data);
                                pos_next   = POS_W'(rda_reg);
                            end
                        end
                        CMD_FIND:
                        begin
                            if (hit)
                            begin
                                pos_next   = POS_W'(rda_reg);
                                issue_next = 1'b0;
                                rdv_next   = 1'b0;
                                state_next = S_DONE;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (rda_reg == a_reg)
                            begin
                                hold_next = rd_data;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = a_reg[AW-1:0];
                            end
                        end
                        CMD_GET:
                        begin
                            vout_next = VAL_W'(rd_data);
                        end
                        default:
                        begin
                        end
                    endcase

                    // last word of the walk
                    if (!issue_reg)
                    begin
                        rdv_next = 1'b0;
                        unique case (cmd_reg)
                            CMD_INSERT, CMD_SWAP:
                            begin
                                state_next = S_WRITE;
                            end
                            CMD_REM_POS:
                            begin
                                len_next   = len_reg - LW'(1);
                                state_next = S_DONE;
                            end
                            CMD_REM_VAL:
                            begin
                                if (found_reg || hit)
                                begin
                                    len_next = len_reg - LW'(1);
                                end
                                else
                                begin
                                    status_next = ST_MISSING;
                                end
                                state_next = S_DONE;
                            end
                            CMD_FIND:
                            begin
                                if (!hit)
                                begin
                                    status_next = ST_MISSING;
                                end
                                state_next = S_DONE;
                            end
                            default:
                            begin
                                state_next = S_DONE;
                            end
                        endcase
                    end
                end
            end

            S_WRITE:
            begin
                // new word for insert, first word for swap
                wr_en   = 1'b1;
                wr_addr = wadr_reg[AW-1:0];
                wr_data = hold_reg;
                if (cmd_reg == CMD_INSERT)
                begin
                    len_next = len_reg + LW'(1);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (done_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            ptr_reg   <= '0;
            end_reg   <= '0;
            down_reg  <= 1'b0;
            issue_reg <= 1'b0;
            rdv_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ptr_reg   <= ptr_next;
            end_reg   <= end_next;
            down_reg  <= down_next;
            issue_reg <= issue_next;
            rdv_reg   <= rdv_next;
            found_reg <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        a_reg      <= a_next;
        rda_reg    <= rda_next;
        wadr_reg   <= wadr_next;
        w_reg      <= w_next;
        hold_reg   <= hold_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        pos_reg    <= pos_next;
    end

endmodule

[design/ordered_list_engine.sv]
// Throughput: one request at a time, one store word a cycle; a new request is taken while
// a response waits in the output register.
// Reset clears the length and all control state; the word store itself is not cleared.
// ----------------------------------------------------------------------------
// ordered_list_engine
// Indexed sequence of signed words with insert, remove, swap, get, find and
// clear requests; one response per request through an output register.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = ole_pkg::WORD_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ole_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_stall,
    output ole_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_stall
);

    import ole_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [WORD_WIDTH-1:0] rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;

    rsp_t done_rsp;
    logic done_valid;
    logic done_take;

    rsp_t rsp_reg;
    logic rsp_valid_reg, rsp_valid_next;

    // sequencer
    ole_ctrl #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .done_rsp   (done_rsp),
        .done_valid (done_valid),
        .done_take  (done_take),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // word store
    ole_mem #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register: load when empty or being drained
    assign done_take = done_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (done_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_take)
        begin
            rsp_reg <= done_rsp;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

[tb/ordered_list_engine_test.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine_test
// Self-checking bench for the ordered list engine. A directed table covers
// empty and full lists, head insert, removal of the last word, bad positions
// and a missing value. Random requests then grow and shrink the list. Every
// response is checked field by field against a typed row's own response or
// an in-bench list model, with random request gaps and response stalls.
// ----------------------------------------------------------------------------
module ordered_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int TABLE_ROWS   = 39;

    // spare selector, answered with ok and no change
    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
    localparam rsp_t NO_RSP = '0;

    // one row of the directed table: typed rows carry their own response
    typedef struct packed {
        logic typed;
        req_t r;
        rsp_t want;
    } step_t;

    logic clk;
    logic rst_n;
    req_t req;
    logic req_valid;
    logic req_stall;
    rsp_t rsp;
    logic rsp_valid;
    logic rsp_stall;

    // list model and response store
    logic [VAL_W-1:0] list_words [DEPTH];
    int               list_len = 0;
    rsp_t             pending_rsp [$];
    int               errors = 0;
    int               idle_cycles = 0;
    bit               quiet_phase = 1'b0;

    step_t directed_steps [TABLE_ROWS] = '{
        '{1'b1, '{CMD_GET,     5'd0,  5'd0,  32'h0},        '{ST_RANGE,   32'h0, 4'd0, 5'd0}},
        '{1'b1, '{CMD_FIND,    5'd0,  5'd0,  32'h0},        '{ST_MISSING, 32'h0, 4'd0, 5'd0}},
        '{1'b1, '{CMD_REM_VAL, 5'd0,  5'd0,  32'hffffffff}, '{ST_MISSING, 32'h0, 4'd0, 5'd0}},
        '{1'b1, '{CMD_REM_POS, 5'd31, 5'd31, 32'h0},        '{ST_RANGE,   32'h0, 4'd0, 5'd0}},
        '{1'b1, '{CMD_INSERT,  5'd1,  5'd0,  32'h5},        '{ST_RANGE,   32'h0, 4'd0, 5'd0}},
        '{1'b1, '{CMD_INSERT,  5'd0,  5'd0,  32'h7fffffff}, '{ST_OK, 32'h0, 4'd0, 5'd1}},
        '{1'b1, '{CMD_INSERT,  5'd0,  5'd0,  32'h80000000}, '{ST_OK, 32'h0, 4'd0, 5'd2}},
        '{1'b1, '{CMD_GET,     5'd1,  5'd0,  32'h0},        '{ST_OK, 32'h7fffffff, 4'd0, 5'd2}},
        '{1'b1, '{CMD_SWAP,    5'd1,  5'd1,  32'h0},        '{ST_RANGE,   32'h0, 4'd0, 5'd2}},
        '{1'b0, '{CMD_SWAP,    5'd0,  5'd1,  32'h0},        NO_RSP},
        '{1'b1, '{CMD_REM_VAL, 5'd0,  5'd0,  32'h80000000}, '{ST_OK, 32'h80000000, 4'd1, 5'd1}},
        '{1'b1, '{CMD_REM_POS, 5'd0,  5'd0,  32'h0},        '{ST_OK, 32'h7fffffff, 4'd0, 5'd0}},
        '{1'b1, '{CMD_GET,     5'd0,  5'd0,  32'h0},        '{ST_RANGE,   32'h0, 4'd0, 5'd0}},
        '{1'b0, '{CMD_INSERT,  5'd0,  5'd31, 32'hffffffff}, NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd1,  5'd0,  32'h0},        NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd0,  5'd31, 32'h1},        NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd3,  5'd0,  32'h55555555}, NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd2,  5'd31, 32'haaaaaaaa}, NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd5,  5'd0,  32'h7fffffff}, NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd0,  5'd0,  32'h80000000}, NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd7,  5'd31, 32'hffffffff}, NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd4,  5'd0,  32'h12345678}, NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd9,  5'd0,  32'h0},        NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd10, 5'd0,  32'h9},        NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd0,  5'd31, 32'hffffff9c}, NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd12, 5'd0,  32'h2a},       NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd6,  5'd0,  32'hfedcba98}, NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd14, 5'd0,  32'h3},        NO_RSP},
        '{1'b0, '{CMD_INSERT,  5'd15, 5'd0,  32'h0f0f0f0f}, NO_RSP},
        '{1'b1, '{CMD_INSERT,  5'd0,  5'd0,  32'h1},        '{ST_FULL,  32'h0, 4'd0, 5'd16}},
        '{1'b1, '{CMD_INSERT,  5'd16, 5'd0,  32'h1},        '{ST_FULL,  32'h0, 4'd0, 5'd16}},
        '{1'b1, '{CMD_INSERT,  5'd17, 5'd0,  32'h1},        '{ST_RANGE, 32'h0, 4'd0, 5'd16}},
        '{1'b0, '{CMD_SWAP,    5'd0,  5'd15, 32'h0},        NO_RSP},
        '{1'b0, '{CMD_GET,     5'd15, 5'd0,  32'h0},        NO_RSP},
        '{1'b0, '{CMD_FIND,    5'd0,  5'd0,  32'hffffffff}, NO_RSP},
        '{1'b0, '{CMD_REM_VAL, 5'd0,  5'd0,  32'h0},        NO_RSP},
        '{1'b1, '{CMD_SWAP,    5'd31, 5'd0,  32'h0},        '{ST_RANGE, 32'h0, 4'd0, 5'd15}},
        '{1'b1, '{CMD_SPARE,   5'd3,  5'd3,  32'h0},        '{ST_OK,    32'h0, 4'd0, 5'd15}},
        '{1'b1, '{CMD_CLEAR,   5'd0,  5'd0,  32'h0},        '{ST_OK,    32'h0, 4'd0, 5'd0}}
    };

    ordered_list_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // first position holding a word, or the length when absent
    function automatic int locate_word(logic [VAL_W-1:0] w);
        int i;
        for (i = 0; i < list_len; i++)
        begin
            if (list_words[i] == w)
                return i;
        end
        return list_len;
    endfunction

    // close the gap left by a removed word
    function automatic void drop_word(int pos);
        int i;
        for (i = pos; i + 1 < list_len; i++)
            list_words[i] = list_words[i + 1];
        list_len--;
    endfunction

    // carry out one request on the list model and form its response
    function automatic rsp_t apply_list_op(req_t r);
        rsp_t             o;
        int               i;
        int               p;
        logic [VAL_W-1:0] held;
        o = '0;
        o.status = ST_OK;
        case (r.cmd)
            CMD_INSERT:
            begin
                if (r.index_a > list_len)
                    o.status = ST_RANGE;
                else if (list_len >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > r.index_a; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[r.index_a] = r.value_in;
                    list_len++;
                end
            end
            CMD_REM_POS:
            begin
                if (r.index_a >= list_len)
                    o.status = ST_RANGE;
                else
                begin
                    o.value_out = list_words[r.index_a];
                    drop_word(r.index_a);
                end
            end
            CMD_REM_VAL:
            begin
                p = locate_word(r.value_in);
                if (p >= list_len)
                    o.status = ST_MISSING;
                else
                begin
                    o.value_out = list_words[p];
                    o.position_out = POS_W'(p);
                    drop_word(p);
                end
            end
            CMD_SWAP:
            begin
                if (r.index_a >= list_len || r.index_b >= list_len || r.index_a == r.index_b)
                    o.status = ST_RANGE;
                else
                begin
                    held = list_words[r.index_a];
                    list_words[r.index_a] = list_words[r.index_b];
                    list_words[r.index_b] = held;
                end
            end
            CMD_GET:
            begin
                if (r.index_a >= list_len)
                    o.status = ST_RANGE;
                else
                    o.value_out = list_words[r.index_a];
            end
            CMD_FIND:
            begin
                p = locate_word(r.value_in);
                if (p >= list_len)
                    o.status = ST_MISSING;
                else
                    o.position_out = POS_W'(p);
            end
            CMD_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        o.length_out = LENO_W'(list_len);
        return o;
    endfunction

    // position inside the list most of the time, any position otherwise
    function automatic logic [IDX_W-1:0] pick_position(bit for_insert);
        if ($urandom_range(0, 6) == 0)
            return IDX_W'($urandom_range(0, 31));
        if (for_insert)
            return IDX_W'($urandom_range(0, list_len));
        if (list_len == 0)
            return '0;
        return IDX_W'($urandom_range(0, list_len - 1));
    endfunction

    // random request; grow_w sets the share of inserts
    function automatic req_t make_request(int grow_w);
        req_t r;
        int   roll;
        r = '0;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < grow_w)
            r.cmd = CMD_INSERT;
        else if (roll < 22)
            r.cmd = CMD_REM_POS;
        else if (roll < 38)
            r.cmd = CMD_REM_VAL;
        else if (roll < 55)
            r.cmd = CMD_SWAP;
        else if (roll < 75)
            r.cmd = CMD_GET;
        else if (roll < 97)
            r.cmd = CMD_FIND;
        else if (roll < 99)
            r.cmd = CMD_CLEAR;
        else
            r.cmd = CMD_SPARE;
        r.index_a = pick_position(r.cmd == CMD_INSERT);
        if (r.cmd == CMD_SWAP)
            r.index_b = pick_position(1'b0);
        else
            r.index_b = IDX_W'($urandom_range(0, 31));
        // words: stored ones so searches hit, small, extreme or fully random
        case ($urandom_range(0, 4))
            0:
                r.value_in = $urandom();
            1, 2:
            begin
                if (list_len > 0)
                    r.value_in = list_words[$urandom_range(0, list_len - 1)];
                else
                    r.value_in = $urandom();
            end
            3:
                r.value_in = $urandom_range(0, 6) - 3;
            default:
                r.value_in = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
        return r;
    endfunction

    // request gaps: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // present one request until taken, then log its response
    task automatic send_request(req_t r, logic typed, rsp_t want);
        rsp_t predicted;
        req = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = apply_list_op(r);
        pending_rsp.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic hold_off();
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // request side
    initial
    begin
        int   n;
        int   grow_w;
        req_t r;
        req = '0;
        req_valid = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        for (n = 0; n < TABLE_ROWS; n++)
        begin
            hold_off();
            send_request(directed_steps[n].r, directed_steps[n].typed, directed_steps[n].want);
        end

        // random requests in phases that grow, hold and shrink the list
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
                quiet_phase = ($urandom_range(0, 3) == 0);
            case ((n / 120) % 3)
                0:       grow_w = 60;
                1:       grow_w = 35;
                default: grow_w = 15;
            endcase
            r = make_request(grow_w);
            hold_off();
            send_request(r, 1'b0, NO_RSP);
        end
        req_valid = 1'b0;

        // drain
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // response stalls: free runs broken by short or long holds
    initial
    begin
        int free_run;
        int hold;
        rsp_stall = 1'b0;
        forever
        begin
            free_run = $urandom_range(1, 20);
            repeat (free_run) @(negedge clk) rsp_stall = 1'b0;
            if (quiet_phase)
                hold = 0;
            else if ($urandom_range(0, 9) < 8)
                hold = $urandom_range(1, 3);
            else
                hold = $urandom_range(10, 30);
            repeat (hold) @(negedge clk) rsp_stall = 1'b1;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // response checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response with none expected, actual %0h", $time, rsp);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("value_out", want.value_out, rsp.value_out);
                check_field("position_out", 32'(want.position_out), 32'(rsp.position_out));
                check_field("length_out", 32'(want.length_out), 32'(rsp.length_out));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule
